>>> hw/rtl/lh_pkg.sv
// lh_pkg: shared types and constants for the luminance histogram.
// No dependencies; imported by luma_histogram.
`default_nettype none

package lh_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = 8;
  localparam int CHAN_W      = 8;
  localparam int WEIGHT_W    = 16;
  localparam int PROD_W      = WEIGHT_W + CHAN_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int FRAC_W      = 16;
  localparam int TOTAL_W     = 32;
  localparam int OUT_COUNT_W = 24;
  localparam int CFG_IDX_W   = 8;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE  = 8'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 16'd19595;
  localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 16'd38470;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 16'd7471;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [BIN_W-1:0] bin_t;

endpackage

`default_nettype wire

>>> hw/rtl/luma_histogram.sv
// luma_histogram: 256-bin luma histogram with read-and-clear, bins in one RAM.
// Depends on lh_pkg (types, constants, register indexes).
`default_nettype none

// Pipeline: an accepted item passes through the registered stages
//   (products, luma/bin, RAM read + update, output register).
// Throughput: one item per clock unless m_tready stalls; the bin RAM does at most
//   one read and one write-back each cycle, back-to-back hits on a bin are forwarded.
// Reset (rst, synchronous): weights to defaults, pixel total to zero, all
//   bins read as zero at once through per-bin valid flops; no clearing pass.
module luma_histogram
  import lh_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input items
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [31:0]          s_tdata,   // red[7:0], green[15:8], blue[23:16], read_bin[31:24]
  input  wire logic                 s_tuser,   // action[0]
  // result items
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,   // bin[7:0], bin_count[31:8], pixel_total[63:32]
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WEIGHT_W-1:0]  cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // ---------------- configuration ----------------
  logic [WEIGHT_W-1:0] weight_red, weight_green, weight_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_red   <= WEIGHT_RED_RST;
      weight_green <= WEIGHT_GREEN_RST;
      weight_blue  <= WEIGHT_BLUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WEIGHT_RED:   weight_red   <= cfg_data;
        REG_WEIGHT_GREEN: weight_green <= cfg_data;
        REG_WEIGHT_BLUE:  weight_blue  <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic p1_valid, p2_valid, p3_valid, out_valid;
  logic out_free, p3_adv, p3_free, p2_adv, p2_free, p1_adv, p1_free;
  logic in_acc;

  assign out_free = !out_valid || m_tready;
  assign p3_adv   = p3_valid && out_free;
  assign p3_free  = !p3_valid || p3_adv;
  assign p2_adv   = p2_valid && p3_free;
  assign p2_free  = !p2_valid || p2_adv;
  assign p1_adv   = p1_valid && p2_free;
  assign p1_free  = !p1_valid || p1_adv;
  assign s_tready = p1_free;
  assign in_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p1_free) p1_valid  <= in_acc;
      if (p2_free) p2_valid  <= p1_adv;
      if (p3_free) p3_valid  <= p2_adv;
      if (out_free) out_valid <= p3_adv;
    end
  end

  // ---------------- stage 1: weighted channels ----------------
  logic              p1_action;
  bin_t              p1_read_bin;
  logic [PROD_W-1:0] p1_prod_r, p1_prod_g, p1_prod_b;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_action   <= s_tuser;
      p1_read_bin <= s_tdata[31:24];
      p1_prod_r   <= PROD_W'(weight_red)   * PROD_W'(s_tdata[7:0]);
      p1_prod_g   <= PROD_W'(weight_green) * PROD_W'(s_tdata[15:8]);
      p1_prod_b   <= PROD_W'(weight_blue)  * PROD_W'(s_tdata[23:16]);
    end
  end

  // ---------------- stage 2: luma to bin (or read bin) ----------------
  logic             p2_action;
  bin_t             p2_idx;
  logic [SUM_W-1:0] luma_sum;
  logic [SUM_W-FRAC_W-1:0] luma_int;
  bin_t             luma_bin;

  always_comb begin
    luma_sum = SUM_W'(p1_prod_r) + SUM_W'(p1_prod_g) + SUM_W'(p1_prod_b);
    luma_int = luma_sum[SUM_W-1:FRAC_W];
    // luma above range saturates to the top bin
    luma_bin = (luma_int[SUM_W-FRAC_W-1:BIN_W] != '0) ? '1 : luma_int[BIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_action <= p1_action;
      p2_idx    <= (p1_action == ACT_READ) ? p1_read_bin : luma_bin;
    end
  end

  // ---------------- bin RAM with read-modify-write ----------------
  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_written;  // clear = bin reads as zero
  logic [COUNT_BITS-1:0] rd_data, fwd_data, wr_data;
  logic                  rd_hit, fwd;
  logic                  p3_action;
  bin_t                  p3_idx;

  always_ff @(posedge clk) begin
    if (p3_adv) bin_mem[p3_idx] <= wr_data;
    if (p2_adv) rd_data <= bin_mem[p2_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_written <= '0;
    end else if (p3_adv) begin
      bin_written[p3_idx] <= 1'b1;
    end
  end

  // A write-back in the same cycle as the read of the same bin is forwarded.
  always_ff @(posedge clk) begin
    if (p2_adv) begin
      p3_action <= p2_action;
      p3_idx    <= p2_idx;
      rd_hit    <= bin_written[p2_idx];
      fwd       <= p3_adv && (p3_idx == p2_idx);
      fwd_data  <= wr_data;
    end
  end

  logic [COUNT_BITS-1:0] cur_count, inc_count;

  always_comb begin
    cur_count = fwd ? fwd_data : (rd_hit ? rd_data : '0);
    inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    wr_data   = (p3_action == ACT_READ) ? '0 : inc_count;
  end

  // ---------------- pixel total ----------------
  logic [TOTAL_W-1:0] pixel_total, pixel_total_next;

  always_comb begin
    pixel_total_next = pixel_total;
    if (p3_action == ACT_ACCUM && pixel_total != TOTAL_MAX)
      pixel_total_next = pixel_total + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= '0;
    end else if (p3_adv) begin
      pixel_total <= pixel_total_next;
    end
  end

  // ---------------- output register ----------------
  bin_t                  out_bin;
  logic                  out_action;
  logic [COUNT_BITS-1:0] out_count;
  logic [TOTAL_W-1:0]    out_total;
  logic [31:0]           out_count_wide;

  always_ff @(posedge clk) begin
    if (p3_adv) begin
      out_bin    <= p3_idx;
      out_action <= p3_action;
      out_count  <= (p3_action == ACT_READ) ? cur_count : inc_count;
      out_total  <= pixel_total_next;
    end
  end

  assign out_count_wide = 32'(out_count);
  assign m_tvalid = out_valid;
  assign m_tdata  = {out_total, out_count_wide[OUT_COUNT_W-1:0], out_bin};

`ifndef SYNTHESIS
  // pixel total never moves backward outside reset
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> pixel_total >= $past(pixel_total))
    else $error("pixel total decreased");

  // a stalled update stage keeps its item
  a_p3_hold: assert property (@(posedge clk) disable iff (rst)
    p3_valid && !out_free |=> p3_valid && $stable(p3_idx) && $stable(p3_action))
    else $error("update stage lost a stalled item");

  // an accumulate result always reports a nonzero count
  a_accum_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action == ACT_ACCUM |-> out_count != '0)
    else $error("accumulate result with zero count");

  // the input side is open whenever the first stage is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !p1_valid |-> s_tready)
    else $error("input stalled with empty first stage");
`endif

endmodule

`default_nettype wire
